>>> sv/multichannel_iir_filter_defines.svh
// Assertion macros for the multichannel IIR filter checker.
// Expect clk and arst_n in the scope of each use.
`ifndef MULTICHANNEL_IIR_FILTER_DEFINES_SVH
`define MULTICHANNEL_IIR_FILTER_DEFINES_SVH

// check a property on every clock edge outside reset
`define MCIIR_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a stalled word stays valid and unchanged
`define MCIIR_HOLD(label, vld, stl, sig, msg) \
	`MCIIR_CHECK(label, (vld && stl) |=> (vld && $stable(sig)), msg)

`endif

>>> sv/mciir_pkg.sv
// Shared types and constants for the multichannel IIR filter.
// No dependencies.
package mciir_pkg;

	localparam int REG_BITS     = 24;
	localparam int STATE_BITS   = 48;
	localparam int CHAN_BITS    = 3;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_GAIN,
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2
	} reg_idx_t;

	typedef logic signed [REG_BITS-1:0]   coef_word_t;
	typedef logic signed [STATE_BITS-1:0] state_word_t;

	typedef struct packed {
		coef_word_t gain;
		coef_word_t b0;
		coef_word_t b1;
		coef_word_t b2;
		coef_word_t a1;
		coef_word_t a2;
	} coef_t;

endpackage

>>> sv/mciir_regs.sv
// Gain and coefficient registers written through the configuration port.
// Depends on mciir_pkg.
module mciir_regs import mciir_pkg::*; #(
	parameter int COEF_FRAC_BITS = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [CFG_IDX_BITS-1:0] wr_index,
	input  logic [REG_BITS-1:0]     wr_data,
	output coef_t                   coef
);

	localparam coef_word_t REG_ONE = REG_BITS'(64'd1 << COEF_FRAC_BITS);

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{gain: REG_ONE, b0: REG_ONE, default: '0};
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_GAIN: coef_q.gain <= wr_data;
				REG_B0:   coef_q.b0   <= wr_data;
				REG_B1:   coef_q.b1   <= wr_data;
				REG_B2:   coef_q.b2   <= wr_data;
				REG_A1:   coef_q.a1   <= wr_data;
				REG_A2:   coef_q.a2   <= wr_data;
				default:  coef_q      <= coef_q;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

>>> sv/mciir_mem.sv
// Delay line memory: one row per channel, registered read.
// Per-row valid bits flag unwritten rows on rd_valid after reset; the reader takes them as zero.
module mciir_mem import mciir_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 96,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	output logic             rd_valid,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

>>> sv/mciir_core.sv
// Sequencer and datapath: gain, output tap and per-tap state update
// over two shared multipliers; reads and writes back the channel row.
module mciir_core import mciir_pkg::*; #(
	parameter int CHANNELS       = 8,
	parameter int ORDER          = 2,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 20,
	parameter int AW             = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  coef_t                         coef,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [CHAN_BITS-1:0]          channel,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [CHAN_BITS-1:0]          channel_out,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          saturated,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [ORDER*STATE_BITS-1:0]   rd_data,
	input  logic                          rd_valid,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [ORDER*STATE_BITS-1:0]   wr_data
);

	localparam int S     = SAMPLE_BITS;
	localparam int XB    = SAMPLE_BITS + 4;
	localparam int PB    = XB + REG_BITS;
	localparam int PA    = SAMPLE_BITS + REG_BITS;
	localparam int ACC_W = ((PB > STATE_BITS) ? PB : STATE_BITS) + 2;
	localparam int JW    = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_X,
		ST_ACC,
		ST_Y,
		ST_MUL,
		ST_SUM
	} state_t;

	function automatic logic [AW-1:0] chan_mod(input logic [CHAN_BITS-1:0] ch);
		logic [AW-1:0] r;
		r = '0;
		for (int k = 0; k < 2**CHAN_BITS; k++) begin
			if (ch == CHAN_BITS'(k)) begin
				r = AW'(k % CHANNELS);
			end
		end
		return r;
	endfunction

	state_t                  state_q;
	logic [JW-1:0]           jj_q;
	logic                    fwd_q;
	logic                    out_valid_q;
	logic [CHAN_BITS-1:0]    channel_out_q;
	logic signed [S-1:0]     sample_out_q;
	logic                    saturated_q;

	logic [CHAN_BITS-1:0]    ch_q;
	logic [AW-1:0]           idx_q;
	logic signed [S-1:0]     sample_q;
	logic signed [XB-1:0]    x_q;
	logic signed [S-1:0]     y_q;
	logic signed [PB-1:0]    prod_b_q;
	logic signed [PA-1:0]    prod_a_q;
	state_word_t             zrow_q [ORDER];

	logic                    accept;
	logic                    last_j;
	logic                    y_go;
	logic signed [XB-1:0]    mul_l;
	coef_word_t              mul_r;
	coef_word_t              b_sel;
	coef_word_t              a_sel;
	logic signed [PB-1:0]    mul_b;
	logic signed [PA-1:0]    mul_a;
	logic signed [ACC_W-1:0] x_rnd;
	logic                    x_ovf;
	logic signed [XB-1:0]    x_sat;
	logic signed [ACC_W-1:0] y_rnd;
	logic                    y_ovf;
	logic signed [S-1:0]     y_sat;
	logic signed [ACC_W-1:0] z_in;
	logic signed [ACC_W-1:0] z_sum;
	logic                    z_ovf;
	state_word_t             z_new;
	state_word_t             row_next [ORDER];
	state_word_t             row_rd [ORDER];

	assign last_j   = (jj_q == JW'(ORDER - 1));
	assign in_stall = !((state_q == ST_IDLE) || ((state_q == ST_SUM) && last_j));
	assign accept   = in_valid && !in_stall;
	assign y_go     = (state_q == ST_Y) && (!out_valid_q || !out_stall);

	always_comb begin
		b_sel = '0;
		a_sel = '0;
		if (jj_q == JW'(0)) begin
			b_sel = coef.b1;
			a_sel = coef.a1;
		end else if (jj_q == JW'(1)) begin
			b_sel = coef.b2;
			a_sel = coef.a2;
		end
	end

	always_comb begin
		case (state_q)
			ST_GAIN: begin
				mul_l = XB'(sample_q);
				mul_r = coef.gain;
			end
			ST_ACC: begin
				mul_l = x_q;
				mul_r = coef.b0;
			end
			ST_MUL: begin
				mul_l = x_q;
				mul_r = b_sel;
			end
			default: begin
				mul_l = '0;
				mul_r = '0;
			end
		endcase
	end

	assign mul_b = mul_l * mul_r;
	assign mul_a = y_q * a_sel;

	assign x_rnd = (ACC_W'(prod_b_q) + RND) >>> COEF_FRAC_BITS;
	assign x_ovf = !((&x_rnd[ACC_W-1:XB-1]) || !(|x_rnd[ACC_W-1:XB-1]));
	assign x_sat = x_ovf ? {x_rnd[ACC_W-1], {(XB-1){~x_rnd[ACC_W-1]}}} : x_rnd[XB-1:0];

	assign y_rnd = (ACC_W'(prod_b_q) + ACC_W'(zrow_q[0]) + RND) >>> COEF_FRAC_BITS;
	assign y_ovf = !((&y_rnd[ACC_W-1:S-1]) || !(|y_rnd[ACC_W-1:S-1]));
	assign y_sat = y_ovf ? {y_rnd[ACC_W-1], {(S-1){~y_rnd[ACC_W-1]}}} : y_rnd[S-1:0];

	always_comb begin
		z_in = '0;
		for (int k = 0; k < ORDER - 1; k++) begin
			if (jj_q == JW'(k)) begin
				z_in = ACC_W'(zrow_q[k+1]);
			end
		end
	end

	assign z_sum = ACC_W'(prod_b_q) - ACC_W'(prod_a_q) + z_in;
	assign z_ovf = !((&z_sum[ACC_W-1:STATE_BITS-1]) || !(|z_sum[ACC_W-1:STATE_BITS-1]));
	assign z_new = z_ovf ? {z_sum[ACC_W-1], {(STATE_BITS-1){~z_sum[ACC_W-1]}}}
		: z_sum[STATE_BITS-1:0];

	always_comb begin
		for (int k = 0; k < ORDER; k++) begin
			row_next[k] = (jj_q == JW'(k)) ? z_new : zrow_q[k];
			row_rd[k]   = rd_valid ? rd_data[k*STATE_BITS +: STATE_BITS] : '0;
			wr_data[k*STATE_BITS +: STATE_BITS] = row_next[k];
		end
	end

	assign rd_en   = accept;
	assign rd_addr = chan_mod(channel);
	assign wr_en   = (state_q == ST_SUM) && last_j;
	assign wr_addr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			jj_q          <= '0;
			fwd_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			channel_out_q <= '0;
			sample_out_q  <= '0;
			saturated_q   <= 1'b0;
		end else begin
			if (y_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fwd_q   <= 1'b0;
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: state_q <= ST_X;
				ST_X:    state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_Y;
				ST_Y: begin
					if (y_go) begin
						channel_out_q <= ch_q;
						sample_out_q  <= y_sat;
						saturated_q   <= y_ovf;
						jj_q          <= '0;
						state_q       <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: begin
					if (last_j) begin
						if (in_valid) begin
							fwd_q   <= (chan_mod(channel) == idx_q);
							state_q <= ST_GAIN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						jj_q    <= JW'(jj_q + 1'b1);
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= channel;
			idx_q    <= chan_mod(channel);
			sample_q <= sample_in;
		end
		if (state_q == ST_GAIN) begin
			prod_b_q <= mul_b;
			if (!fwd_q) begin
				zrow_q <= row_rd;
			end
		end
		if (state_q == ST_X) begin
			x_q <= x_sat;
		end
		if (state_q == ST_ACC) begin
			prod_b_q <= mul_b;
		end
		if (y_go) begin
			y_q <= y_sat;
		end
		if (state_q == ST_MUL) begin
			prod_b_q <= mul_b;
			prod_a_q <= mul_a;
		end
		if (state_q == ST_SUM) begin
			zrow_q <= row_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = channel_out_q;
	assign sample_out  = sample_out_q;
	assign saturated   = saturated_q;

endmodule

>>> sv/multichannel_iir_filter.sv
// Multichannel IIR filter, transposed direct form II, shared coefficients.
// The result word is registered at the end of the Y state, after the gain, x and b0 steps.
// A new word is taken only once the last one is through: the two shared multipliers
// step through the taps of the channel row held in the delay memory, and a stalled output holds it.
// Reset: coefficients to their defaults, delay lines read as zero through per-row
// valid bits, so input is taken right after reset.
module multichannel_iir_filter import mciir_pkg::*; #(
	parameter int CHANNELS       = 8,
	parameter int ORDER          = 2,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [REG_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [CHAN_BITS-1:0]          channel,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [CHAN_BITS-1:0]          channel_out,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          saturated
);

	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ROW_W = ORDER * STATE_BITS;

	coef_t            coef;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [ROW_W-1:0] rd_data;
	logic             rd_valid;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [ROW_W-1:0] wr_data;

	assign cfg_ready = 1'b1;

	mciir_regs #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.coef    (coef)
	);

	mciir_mem #(
		.DEPTH(CHANNELS),
		.WIDTH(ROW_W),
		.AW   (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_valid(rd_valid),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mciir_core #(
		.CHANNELS      (CHANNELS),
		.ORDER         (ORDER),
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.AW            (AW)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.channel    (channel),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel_out(channel_out),
		.sample_out (sample_out),
		.saturated  (saturated),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.rd_valid   (rd_valid),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

endmodule

>>> sv/mciir_check.sv
// Port-level checker for the multichannel IIR filter, bound to the top level.
// Depends on mciir_pkg and multichannel_iir_filter_defines.svh.
`include "multichannel_iir_filter_defines.svh"

module mciir_check import mciir_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic [CHAN_BITS-1:0]   channel,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [CHAN_BITS-1:0]   channel_out,
	input logic [SAMPLE_BITS-1:0] sample_out,
	input logic                   saturated
);

	`MCIIR_HOLD(a_out_hold, out_valid, out_stall, sample_out, "stalled output word changed")

	`MCIIR_CHECK(a_one_word, (in_valid && !in_stall) |=> in_stall, "input taken while busy")

	`MCIIR_CHECK(a_result_timing, $rose(out_valid) |-> ($past(in_valid && !in_stall, 5) && (channel_out == $past(channel, 5))), "result word not aligned with its input word")

	`MCIIR_CHECK(a_sat_limit, (out_valid && saturated) |-> (sample_out[SAMPLE_BITS-2:0] == {(SAMPLE_BITS-1){~sample_out[SAMPLE_BITS-1]}}), "saturated word not at a range limit")

endmodule

bind multichannel_iir_filter mciir_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_check (.*);

>>> sim/tb_multichannel_iir_filter.sv
`timescale 1ns / 1ps
// Testbench for multichannel_iir_filter: directed table, then random coefficient phases;
// each word is checked against a transposed direct form II model or the typed row's word.
// Depends on mciir_pkg and the multichannel_iir_filter RTL.
module tb_multichannel_iir_filter;
	import mciir_pkg::*;

	localparam int FILT_CHANNELS  = 8;
	localparam int FILT_ORDER     = 2;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 20;
	localparam int PHASES         = 11;
	localparam int PHASE_ITEMS    = 150;
	localparam int DRAIN_CYCLES   = 12;
	localparam int CYCLE_LIMIT    = 400000;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

	localparam coef_word_t Q_ONE     = 24'sd1048576;
	localparam coef_word_t Q_HALF    = 24'sd524288;
	localparam coef_word_t Q_QUARTER = 24'sd262144;
	localparam coef_word_t Q_MAX     = 24'sh7FFFFF;
	localparam coef_word_t Q_MIN     = 24'sh800000;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;

	typedef struct packed {
		logic [CHAN_BITS-1:0]          chan;
		logic signed [SAMPLE_BITS-1:0] smp;
		logic                          sat;
	} filt_word_t;

	typedef struct packed {
		logic                    is_cfg;
		logic [CFG_IDX_BITS-1:0] sel;
		logic [REG_BITS-1:0]     word;
		logic                    typed;
		logic [SAMPLE_BITS-1:0]  want;
		logic                    want_sat;
	} step_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_BITS-1:0]       cfg_index;
	logic [REG_BITS-1:0]           cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [CHAN_BITS-1:0]          channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          out_valid;
	logic                          out_stall;
	logic [CHAN_BITS-1:0]          channel_out;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          saturated;

	coef_word_t  gain_q = Q_ONE;
	coef_word_t  b0_q   = Q_ONE;
	coef_word_t  b1_q   = '0;
	coef_word_t  b2_q   = '0;
	coef_word_t  a1_q   = '0;
	coef_word_t  a2_q   = '0;
	state_word_t taps [FILT_CHANNELS][FILT_ORDER] = '{default: '0};

	filt_word_t due_outputs [$];
	step_row_t  directed_steps [];
	int         mismatch_count = 0;
	int         cycle_count    = 0;
	bit         calm           = 1'b0;

	multichannel_iir_filter #(
		.CHANNELS(FILT_CHANNELS),
		.ORDER(FILT_ORDER),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.channel(channel),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.channel_out(channel_out),
		.sample_out(sample_out),
		.saturated(saturated)
	);

	function automatic longint clamp_signed(input longint v, input int w, output bit hit);
		longint hi;
		longint lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		hit = (v > hi) || (v < lo);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint round_q(input longint v);
		return (v + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
	endfunction

	function automatic filt_word_t filter_sample(input logic [CHAN_BITS-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] smp);
		int unsigned row_sel;
		longint      x;
		longint      acc;
		longint      y;
		bit          hit;
		bit          clip;
		filt_word_t  res;
		row_sel = ch % FILT_CHANNELS;
		x = clamp_signed(round_q(longint'(smp) * longint'(gain_q)), SAMPLE_BITS + 4, hit);
		acc = longint'(b0_q) * x + longint'(taps[row_sel][0]);
		y = clamp_signed(round_q(acc), SAMPLE_BITS, clip);
		taps[row_sel][0] = STATE_BITS'(clamp_signed(longint'(b1_q) * x
			+ longint'(taps[row_sel][1]) - longint'(a1_q) * y, STATE_BITS, hit));
		taps[row_sel][1] = STATE_BITS'(clamp_signed(longint'(b2_q) * x
			- longint'(a2_q) * y, STATE_BITS, hit));
		res.chan = ch;
		res.smp  = y[SAMPLE_BITS-1:0];
		res.sat  = clip;
		return res;
	endfunction

	function automatic step_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
			input coef_word_t val);
		return '{is_cfg: 1'b1, sel: idx, word: val, typed: 1'b0, want: '0, want_sat: 1'b0};
	endfunction

	function automatic step_row_t chk_row(input logic [CHAN_BITS-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] smp);
		return '{is_cfg: 1'b0, sel: ch, word: smp, typed: 1'b0, want: '0, want_sat: 1'b0};
	endfunction

	function automatic step_row_t typed_row(input logic [CHAN_BITS-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] smp,
			input logic signed [SAMPLE_BITS-1:0] want, input logic want_sat);
		return '{is_cfg: 1'b0, sel: ch, word: smp, typed: 1'b1, want: want,
			want_sat: want_sat};
	endfunction

	function automatic coef_word_t pick_coef();
		case ($urandom_range(7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return Q_ONE;
			4: return -Q_ONE;
			7: return REG_BITS'($urandom);
			default: return REG_BITS'(int'($urandom_range(0, 2 * Q_HALF)) - Q_HALF);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coef_word_t val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN: gain_q = val;
			REG_B0:   b0_q   = val;
			REG_B1:   b1_q   = val;
			REG_B2:   b2_q   = val;
			REG_A1:   a1_q   = val;
			REG_A2:   a2_q   = val;
			default: ;
		endcase
	endtask

	task automatic send_sample(input logic [CHAN_BITS-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] smp, input bit typed,
			input logic signed [SAMPLE_BITS-1:0] want_smp, input bit want_sat);
		filt_word_t due;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 28) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		channel   = ch;
		sample_in = smp;
		do @(posedge clk); while (in_stall);
		due = filter_sample(ch, smp);
		if (typed) begin
			due.smp = want_smp;
			due.sat = want_sat;
		end
		due_outputs.push_back(due);
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : drain_side
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = !calm && ($urandom_range(99) < 28);
		end
	end

	always @(posedge clk) begin : watch_output
		filt_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_outputs.size() == 0) begin
				$display("%0t: expected no word, got channel %0d sample %0d saturated %0b",
					$time, channel_out, sample_out, saturated);
				mismatch_count++;
			end else begin
				want = due_outputs.pop_front();
				if (channel_out !== want.chan) begin
					$display("%0t: channel_out expected %0d got %0d",
						$time, want.chan, channel_out);
					mismatch_count++;
				end
				if (sample_out !== want.smp) begin
					$display("%0t: sample_out expected %0d got %0d",
						$time, want.smp, sample_out);
					mismatch_count++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %0b got %0b",
						$time, want.sat, saturated);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		step_row_t            row;
		bit                   cfg_active;
		int                   calm_phase;
		logic [CHAN_BITS-1:0] chan;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		channel    = '0;
		sample_in  = '0;
		cfg_active = 1'b0;
		chan       = '0;
		directed_steps = '{
			typed_row(0, SMP_MAX, SMP_MAX, 1'b0),
			typed_row(7, SMP_MIN, SMP_MIN, 1'b0),
			typed_row(3, 24'sd0, 24'sd0, 1'b0),
			typed_row(5, -24'sd1, -24'sd1, 1'b0),
			cfg_row(REG_GAIN, Q_MAX),
			typed_row(1, SMP_MAX, SMP_MAX, 1'b1),
			typed_row(2, SMP_MIN, SMP_MIN, 1'b1),
			typed_row(6, 24'sd0, 24'sd0, 1'b0),
			cfg_row(REG_GAIN, Q_MIN),
			typed_row(4, SMP_MIN, SMP_MAX, 1'b1),
			typed_row(0, SMP_MAX, SMP_MIN, 1'b1),
			cfg_row(REG_GAIN, '0),
			typed_row(1, SMP_MAX, 24'sd0, 1'b0),
			typed_row(6, SMP_MIN, 24'sd0, 1'b0),
			cfg_row(REG_GAIN, Q_ONE),
			cfg_row(REG_B0, Q_HALF),
			cfg_row(REG_B1, Q_HALF),
			cfg_row(REG_B2, -Q_QUARTER),
			cfg_row(REG_A1, -Q_HALF),
			cfg_row(REG_A2, Q_QUARTER),
			chk_row(4, 24'sd1000000),
			chk_row(4, -24'sd300000),
			chk_row(4, 24'sd0),
			chk_row(4, 24'sd0),
			chk_row(0, 24'sd5000),
			cfg_row(REG_GAIN, Q_MAX),
			cfg_row(REG_B0, Q_MAX),
			cfg_row(REG_B1, Q_MAX),
			cfg_row(REG_B2, Q_MIN),
			cfg_row(REG_A1, Q_MIN),
			cfg_row(REG_A2, Q_MAX),
			chk_row(2, SMP_MAX),
			chk_row(2, SMP_MAX),
			chk_row(2, SMP_MAX),
			chk_row(2, SMP_MAX),
			cfg_row(REG_SPARE_LO, Q_MIN),
			cfg_row(REG_SPARE_HI, Q_MAX),
			chk_row(2, SMP_MIN)
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[i]) begin
			row = directed_steps[i];
			if (row.is_cfg) begin
				if (!cfg_active) quiesce();
				cfg_active = 1'b1;
				write_reg(row.sel, row.word);
			end else begin
				if (cfg_active) begin
					@(negedge clk);
					cfg_valid  = 1'b0;
					cfg_active = 1'b0;
				end
				send_sample(row.sel, row.word, row.typed, row.want, row.want_sat);
			end
		end

		calm_phase = $urandom_range(0, PHASES - 1);
		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			calm = (p == calm_phase);
			for (int r = REG_GAIN; r <= REG_A2; r++)
				write_reg(CFG_IDX_BITS'(r), pick_coef());
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
					REG_BITS'($urandom));
			@(negedge clk);
			cfg_valid = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(9) >= 3)
					chan = CHAN_BITS'($urandom_range(0, (1 << CHAN_BITS) - 1));
				send_sample(chan, pick_sample(), 1'b0, '0, 1'b0);
			end
		end
		calm = 1'b0;
		quiesce();

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/mciir_pkg.sv
sv/mciir_regs.sv
sv/mciir_mem.sv
sv/mciir_core.sv
sv/multichannel_iir_filter.sv
sv/mciir_check.sv
sim/tb_multichannel_iir_filter.sv
